// File: sv/typed_integer_alu_macros.svh
// assertion macros for the typed integer alu
`ifndef TYPED_INTEGER_ALU_MACROS_SVH
`define TYPED_INTEGER_ALU_MACROS_SVH
// implication checked at every clock edge outside reset
`define TIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TIA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/tia_pkg.sv
// shared types and codes of the typed alu
package tia_pkg;
  localparam int WordW = 32;
  localparam int ShW = $clog2(WordW);
  localparam int Cells = 32;

  typedef logic [WordW-1:0] word_t;

  localparam logic [4:0] F_NOT = 5'd0, F_NEG = 5'd1, F_AND = 5'd2, F_OR = 5'd3,
    F_XOR = 5'd4, F_ADD = 5'd5, F_SUB = 5'd6, F_MUL = 5'd7, F_DIV = 5'd8,
    F_MOD = 5'd9, F_EQ = 5'd10, F_NE = 5'd11, F_LT = 5'd12, F_LE = 5'd13,
    F_GT = 5'd14, F_GE = 5'd15, F_SHL = 5'd16, F_SHR = 5'd17;
  localparam logic [2:0] K_I = 3'd0, K_U = 3'd1, K_B = 3'd2, K_C = 3'd3;
  localparam logic [2:0] ST_OK = 3'd0, ST_NA = 3'd1, ST_MISMATCH = 3'd2,
    ST_DIVZERO = 3'd3, ST_RANGE = 3'd4;

  // item travelling down the divider cell chain
  typedef struct packed {
    logic       vld;
    logic [2:0] status;
    logic [1:0] kind;
    word_t      word;     // final word for non-division items
    logic       is_div;
    logic       neg_q;
    logic       neg_r;
    logic       want_rem;
    word_t      rem;
    word_t      quo;      // dividend bits shift out, quotient bits shift in
    word_t      dvs;
  } cell_t;
endpackage

// File: sv/typed_integer_alu.sv
// top level of the typed integer alu: front stage, division cell chain, output stage
//
//  channel  | ports                                   | direction
//  input    | start, busy, in_func .. in_wanted_kind  | in (busy out)
//  result   | out_strobe, out_status .. out_result_word | out
//  config   | cfg_we, cfg_data                        | in
//
// one transfer per cycle; busy is always low once reset ends
// each result passes the front stage, 32 division cells and the output stage
// every item walks the whole cell chain so results keep their order
// reset (synchronous, active low) clears valids and sets range check on
// the receiver cannot stall, so there is no back pressure anywhere
module typed_integer_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_func,
  input  logic [2:0]  in_a_kind,
  input  logic [31:0] in_a_word,
  input  logic [2:0]  in_b_kind,
  input  logic [31:0] in_b_word,
  input  logic [2:0]  in_wanted_kind,
  input  logic        cfg_we,
  input  logic        cfg_data,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_result_word
);
  import tia_pkg::*;
  `include "typed_integer_alu_macros.svh"

  logic rce_r;
  logic go;
  cell_t chain [Cells+1];

  // range check register
  always_ff @(posedge clk) begin
    if (!rst_n) rce_r <= 1'b1;
    else if (cfg_we) rce_r <= cfg_data;
  end

  assign busy = !rst_n;
  assign go = start && !busy;

  tia_front u_front (
    .clk(clk), .rst_n(rst_n), .rce(rce_r), .go(go), .f(in_func), .ak(in_a_kind),
    .a(word_t'(in_a_word)), .bk(in_b_kind), .b(word_t'(in_b_word)),
    .wk(in_wanted_kind), .o(chain[0])
  );

  // one cell per quotient bit
  for (genvar g = 0; g < Cells; g++) begin : g_cell
    tia_cell u_cell (.clk(clk), .rst_n(rst_n), .i(chain[g]), .o(chain[g+1]));
  end

  // output stage: sign fix for division, select the word
  logic        strb_r;
  logic [2:0]  st_r;
  logic [1:0]  kd_r;
  logic [31:0] wd_r;
  cell_t       last;
  word_t       qv, rv, dv;
  assign last = chain[Cells];
  assign qv = last.neg_q ? -last.quo : last.quo;
  assign rv = last.neg_r ? -last.rem : last.rem;
  assign dv = last.want_rem ? rv : qv;

  always_ff @(posedge clk) begin
    if (!rst_n) strb_r <= 1'b0;
    else strb_r <= last.vld;
    st_r <= last.status;
    kd_r <= last.kind;
    wd_r <= 32'(last.is_div ? dv : last.word);
  end

  assign out_strobe = strb_r;
  assign out_status = st_r;
  assign out_result_kind = kd_r;
  assign out_result_word = wd_r;

  // an error result carries a zero word and kind
  `TIA_ASSERT_IMP(a_err_zero, clk, rst_n, out_strobe && out_status != ST_OK,
    out_result_word == 32'd0 && out_result_kind == 2'd0)
  // division items never carry an error status
  `TIA_ASSERT_IMP(a_div_ok, clk, rst_n, last.vld && last.is_div, last.status == ST_OK)
  // a booleans result is zero or one
  `TIA_ASSERT_IMP(a_bool, clk, rst_n, out_strobe && out_result_kind == 2'(K_B),
    out_result_word[31:1] == 31'd0)
  // the last cell valid shows as the strobe in the next cycle
  `TIA_ASSERT_NXT(a_strobe, clk, rst_n, last.vld, out_strobe)
endmodule

// File: sv/tia_front.sv
// decode, type checks and the non-division operations; feeds the division chain
module tia_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rce,
  input  logic          go,
  input  logic [4:0]    f,
  input  logic [2:0]    ak,
  input  tia_pkg::word_t a,
  input  logic [2:0]    bk,
  input  tia_pkg::word_t b,
  input  logic [2:0]    wk,
  output tia_pkg::cell_t o
);
  import tia_pkg::*;
  cell_t o_r, o_nxt;
  assign o = o_r;

  always_comb begin
    logic num, sg, lt, gt, eq, div0;
    logic [1:0] rk;
    logic [2:0] st;
    word_t rw, ma, mb;
    logic [ShW-1:0] sh;
    logic [2*WordW-1:0] prod;
    rk = 2'(K_I);
    rw = '0;
    st = ST_OK;
    num = (ak == K_I || ak == K_U) && (bk == K_I || bk == K_U);
    sg = (ak == K_I);
    eq = (a == b);
    lt = sg ? ((a ^ {1'b1, {(WordW-1){1'b0}}}) < (b ^ {1'b1, {(WordW-1){1'b0}}})) : (a < b);
    gt = !lt && !eq;
    sh = b[ShW-1:0];
    prod = a * b;
    div0 = (b == '0);
    ma = a;
    mb = b;
    o_nxt = '0;
    if (f == F_NOT || f == F_NEG) begin
      unique case (ak)
        K_I: begin rk = 2'(K_I); rw = (f == F_NOT) ? ~a : -a; end
        K_U: begin
          if (f == F_NOT) begin rk = 2'(K_U); rw = ~a; end
          else if (rce && a[WordW-1]) st = ST_RANGE;
          else begin rk = 2'(K_I); rw = -a; end
        end
        K_B: if (f != F_NOT) st = ST_NA; else begin rk = 2'(K_B); rw = word_t'(!a[0]); end
        default: st = ST_MISMATCH;
      endcase
    end else begin
      if (f >= F_AND && f <= F_XOR && ak == K_B && bk == K_B) begin
        rk = 2'(K_B);
        rw = word_t'((f == F_AND) ? (a[0] & b[0]) : (f == F_OR) ? (a[0] | b[0])
                                  : (a[0] ^ b[0]));
      end else if (f >= F_EQ && f <= F_GE) begin
        if (ak == K_C && bk == K_C) begin
          eq = (a[7:0] == b[7:0]);
          lt = a[7:0] < b[7:0];
          gt = !lt && !eq;
        end else if (!num) st = ST_NA;
        rk = 2'(K_B);
        unique case (f)
          F_EQ: rw = word_t'(eq);
          F_NE: rw = word_t'(!eq);
          F_LT: rw = word_t'(lt);
          F_LE: rw = word_t'(lt || eq);
          F_GT: rw = word_t'(gt);
          default: rw = word_t'(gt || eq);
        endcase
      end else if (!num || f > F_SHR) st = ST_NA;
      else begin
        rk = sg ? 2'(K_I) : 2'(K_U);
        unique case (f)
          F_AND: rw = a & b;
          F_OR: begin rw = a | b; if (ak == K_U && bk == K_I) rk = 2'(K_I); end
          F_XOR: rw = a ^ b;
          F_ADD: rw = a + b;
          F_SUB: rw = a - b;
          F_MUL: rw = prod[WordW-1:0];
          F_DIV, F_MOD: begin
            if (div0) st = ST_DIVZERO;
            else begin
              o_nxt.is_div = 1'b1;
              o_nxt.want_rem = (f == F_MOD);
              if (ak == K_I && bk == K_I) begin
                ma = a[WordW-1] ? -a : a;
                mb = b[WordW-1] ? -b : b;
                o_nxt.neg_q = a[WordW-1] ^ b[WordW-1];
                o_nxt.neg_r = a[WordW-1];
              end
            end
          end
          F_SHL: rw = a << sh;
          default: rw = (sg && a[WordW-1]) ? ~((~a) >> sh) : a >> sh;
        endcase
      end
      if (st == ST_OK && wk != 3'd0 && (wk - 3'd1) != {1'b0, rk}) st = ST_MISMATCH;
    end
    if (st != ST_OK) begin
      rk = 2'(K_I);
      rw = '0;
      o_nxt.is_div = 1'b0;
    end
    o_nxt.vld = go;
    o_nxt.status = st;
    o_nxt.kind = rk;
    o_nxt.word = rw;
    o_nxt.quo = ma;
    o_nxt.dvs = mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_r <= '0;
    else o_r <= o_nxt;
  end
endmodule

// File: sv/tia_cell.sv
// one restoring division step, registered
module tia_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  tia_pkg::cell_t i,
  output tia_pkg::cell_t o
);
  import tia_pkg::*;
  cell_t o_r, o_nxt;
  assign o = o_r;

  always_comb begin
    logic [WordW:0] trial;
    o_nxt = i;
    trial = {i.rem, i.quo[WordW-1]} - {1'b0, i.dvs};
    if (i.is_div) begin
      if (!trial[WordW]) begin
        o_nxt.rem = trial[WordW-1:0];
        o_nxt.quo = {i.quo[WordW-2:0], 1'b1};
      end else begin
        o_nxt.rem = {i.rem[WordW-2:0], i.quo[WordW-1]};
        o_nxt.quo = {i.quo[WordW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_r.vld <= 1'b0;
    else o_r.vld <= o_nxt.vld;
    o_r.status <= o_nxt.status;
    o_r.kind <= o_nxt.kind;
    o_r.word <= o_nxt.word;
    o_r.is_div <= o_nxt.is_div;
    o_r.neg_q <= o_nxt.neg_q;
    o_r.neg_r <= o_nxt.neg_r;
    o_r.want_rem <= o_nxt.want_rem;
    o_r.rem <= o_nxt.rem;
    o_r.quo <= o_nxt.quo;
    o_r.dvs <= o_nxt.dvs;
  end
endmodule
